// ===== rtl/core/beq_pkg.sv =====
package beq_pkg;

	localparam int OP_W = 5;

	localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
	localparam logic [OP_W-1:0] OP_SQT   = 5'd2;
	localparam logic [OP_W-1:0] OP_SQS   = 5'd3;
	localparam logic [OP_W-1:0] OP_ACC   = 5'd4;
	localparam logic [OP_W-1:0] OP_PSTEP = 5'd5;
	localparam logic [OP_W-1:0] OP_MSET  = 5'd6;
	localparam logic [OP_W-1:0] OP_DINIT = 5'd7;
	localparam logic [OP_W-1:0] OP_DSAT  = 5'd8;
	localparam logic [OP_W-1:0] OP_DSTEP = 5'd9;
	localparam logic [OP_W-1:0] OP_NINIT = 5'd10;
	localparam logic [OP_W-1:0] OP_NSTEP = 5'd11;
	localparam logic [OP_W-1:0] OP_LINIT = 5'd12;
	localparam logic [OP_W-1:0] OP_LMUL  = 5'd13;
	localparam logic [OP_W-1:0] OP_LUPD  = 5'd14;
	localparam logic [OP_W-1:0] OP_IMUL  = 5'd15;
	localparam logic [OP_W-1:0] OP_IUPD  = 5'd16;
	localparam logic [OP_W-1:0] OP_IZERO = 5'd17;
	localparam logic [OP_W-1:0] OP_EMUL  = 5'd18;
	localparam logic [OP_W-1:0] OP_EUPD  = 5'd19;
	localparam logic [OP_W-1:0] OP_OUT   = 5'd20;

	// log2 offset of 12 in q16 and 4.24966 in q16
	localparam logic [21:0] K_LOG_OFS  = 22'd786432;
	localparam logic [31:0] K_IDX_GAIN = 32'd278506;
	// 1/4.24966 in q16 and exponent offset of 4 in q16
	localparam logic [21:0] K_DQ_STEP  = 22'd15421;
	localparam logic [21:0] K_DQ_OFS   = 22'd262144;
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [33:0] VAL_MAX    = 34'h3_FFFF_FFFF;
	localparam logic [6:0]  IDX_MAX    = 7'd127;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [5:0]      k;
	} beq_cmd_t;

	typedef struct packed {
		logic band_end;
		logic power_mode;
		logic sat;
		logic env_zero;
		logic env_top;
		logic out_free;
	} beq_stat_t;

	// 2^(2^-(i+1)) in q30
	function automatic logic [31:0] exp2_root(input logic [3:0] i);
		logic [31:0] r;
		unique case (i)
			4'd0:  r = 32'd1518500250;
			4'd1:  r = 32'd1276901417;
			4'd2:  r = 32'd1170923762;
			4'd3:  r = 32'd1121280436;
			4'd4:  r = 32'd1097253708;
			4'd5:  r = 32'd1085434106;
			4'd6:  r = 32'd1079572136;
			4'd7:  r = 32'd1076653033;
			4'd8:  r = 32'd1075196443;
			4'd9:  r = 32'd1074468888;
			4'd10: r = 32'd1074105294;
			4'd11: r = 32'd1073923544;
			4'd12: r = 32'd1073832680;
			4'd13: r = 32'd1073787251;
			4'd14: r = 32'd1073764537;
			default: r = 32'd1073753181;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/band_envelope_quantizer.sv =====
// Band envelope quantizer: one spectral line pair per transfer, one result per closed band.
// A line that does not close its band passes load, the target and source squarings and
// accumulate. A line that closes a band (band_last or frame_last) then runs these steps
// before the next line is taken, plus any output stall: the partial products (power mode),
// 64 steps of the restoring divider (skipped when the quotient saturates), up to 63 normalize
// shifts (skipped for a zero envelope), 16 log2 squarings, the index product and 16 dequantizer
// products. All products share one 32x32 multiplier. The finished result waits until the
// output register is free, and the block holds further input until then.
module band_envelope_quantizer #(
	parameter int MAX_BANDS      = 32,
	parameter int MAX_BAND_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] target_mdct,
	input  logic [47:0]        target_power,
	input  logic signed [23:0] source_mdct,
	input  logic [47:0]        source_power,
	input  logic               band_last,
	input  logic               frame_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         band_number,
	output logic [6:0]         envelope_index,
	output logic [33:0]        envelope_value
);
	import beq_pkg::*;

	beq_cmd_t  cmd;
	beq_stat_t stat;

	beq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	beq_dpath #(
		.MAX_BANDS      (MAX_BANDS),
		.MAX_BAND_WIDTH (MAX_BAND_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.target_mdct    (target_mdct),
		.target_power   (target_power),
		.source_mdct    (source_mdct),
		.source_power   (source_power),
		.band_last      (band_last),
		.frame_last     (frame_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.band_number    (band_number),
		.envelope_index (envelope_index),
		.envelope_value (envelope_value)
	);

endmodule

// ===== rtl/core/beq_ctrl.sv =====
module beq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  beq_pkg::beq_stat_t stat,
	output beq_pkg::beq_cmd_t  cmd
);
	import beq_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SQT   = 4'd1;
	localparam logic [3:0] S_SQS   = 4'd2;
	localparam logic [3:0] S_ACC   = 4'd3;
	localparam logic [3:0] S_PROD  = 4'd4;
	localparam logic [3:0] S_DCHK  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_NINIT = 4'd7;
	localparam logic [3:0] S_NORM  = 4'd8;
	localparam logic [3:0] S_LMUL  = 4'd9;
	localparam logic [3:0] S_LUPD  = 4'd10;
	localparam logic [3:0] S_IMUL  = 4'd11;
	localparam logic [3:0] S_IUPD  = 4'd12;
	localparam logic [3:0] S_EMUL  = 4'd13;
	localparam logic [3:0] S_EUPD  = 4'd14;
	localparam logic [3:0] S_OUT   = 4'd15;

	logic [3:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd.op  = OP_NOP;
		cmd.k   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_SQT;
				end
			end
			S_SQT: begin
				cmd.op  = OP_SQT;
				state_d = S_SQS;
			end
			S_SQS: begin
				cmd.op  = OP_SQS;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op = OP_ACC;
				cnt_d  = '0;
				if (!stat.band_end)
					state_d = S_IDLE;
				else if (stat.power_mode)
					state_d = S_PROD;
				else
					state_d = S_DCHK;
			end
			S_PROD: begin
				cmd.op = OP_PSTEP;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == 6'd6)
					state_d = S_DCHK;
			end
			S_DCHK: begin
				// mdct mode loads operands on the way in
				cnt_d = '0;
				if (!stat.power_mode && cnt_q == 6'd0) begin
					cmd.op = OP_MSET;
					cnt_d  = 6'd1;
				end else if (stat.sat) begin
					cmd.op  = OP_DSAT;
					state_d = S_NINIT;
				end else begin
					cmd.op  = OP_DINIT;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = OP_DSTEP;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == 6'd63)
					state_d = S_NINIT;
			end
			S_NINIT: begin
				cnt_d = '0;
				if (stat.env_zero) begin
					cmd.op  = OP_IZERO;
					state_d = S_EMUL;
				end else begin
					cmd.op  = OP_NINIT;
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				cnt_d = '0;
				if (stat.env_top) begin
					cmd.op  = OP_LINIT;
					state_d = S_LMUL;
				end else begin
					cmd.op = OP_NSTEP;
				end
			end
			S_LMUL: begin
				cmd.op  = OP_LMUL;
				state_d = S_LUPD;
			end
			S_LUPD: begin
				cmd.op = OP_LUPD;
				cnt_d  = cnt_q + 6'd1;
				state_d = (cnt_q == 6'd15) ? S_IMUL : S_LMUL;
			end
			S_IMUL: begin
				cmd.op  = OP_IMUL;
				state_d = S_IUPD;
			end
			S_IUPD: begin
				cmd.op  = OP_IUPD;
				cnt_d   = '0;
				state_d = S_EMUL;
			end
			S_EMUL: begin
				cmd.op  = OP_EMUL;
				state_d = S_EUPD;
			end
			S_EUPD: begin
				cmd.op = OP_EUPD;
				cnt_d  = cnt_q + 6'd1;
				state_d = (cnt_q == 6'd15) ? S_OUT : S_EMUL;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== rtl/core/beq_dpath.sv =====
module beq_dpath #(
	parameter int MAX_BANDS      = 32,
	parameter int MAX_BAND_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  beq_pkg::beq_cmd_t  cmd,
	output beq_pkg::beq_stat_t stat,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic signed [23:0] target_mdct,
	input  logic [47:0]        target_power,
	input  logic signed [23:0] source_mdct,
	input  logic [47:0]        source_power,
	input  logic               band_last,
	input  logic               frame_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         band_number,
	output logic [6:0]         envelope_index,
	output logic [33:0]        envelope_value
);
	import beq_pkg::*;

	localparam int LCW = $clog2(MAX_BAND_WIDTH + 1);
	localparam int BCW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

	logic            pmode_q;
	logic [23:0]     tmag_q, smag_q;
	logic [47:0]     tpow_q, spow_q;
	logic            bend_q, fend_q;
	logic [63:0]     tes_q, tps_q, ses_q, sps_q;
	logic [LCW-1:0]  line_q;
	logic [BCW-1:0]  band_q;
	logic [63:0]     mul_q;
	logic [127:0]    prod_q;
	logic [63:0]     d_q, rem_q, env_q;
	logic [5:0]      p_q;
	logic [30:0]     m_q;
	logic [15:0]     frac_q;
	logic            lneg_q;
	logic [6:0]      idx_q;
	logic [30:0]     acc_q;
	logic            out_valid_q;
	logic [4:0]      band_out_q;
	logic [6:0]      idx_out_q;
	logic [33:0]     val_out_q;

	logic [31:0]     mul_a, mul_b;
	logic            acc_en;
	logic [31:0]     wid;
	logic [63:0]     r2;
	logic [31:0]     sq;
	logic [21:0]     lval;
	logic [63:0]     yv;
	logic [21:0]     e;
	logic [5:0]      n;
	logic            fbit;
	logic [63:0]     v64;
	logic [33:0]     vsat;

	function automatic logic [23:0] mag24(input logic [23:0] v);
		return v[23] ? (24'd0 - v) : v;
	endfunction

	assign acc_en = (32'(line_q) < MAX_BAND_WIDTH);
	assign wid    = (line_q == '0) ? 32'd1 : 32'(line_q);
	assign r2     = {rem_q[62:0], prod_q[63]};
	assign sq     = mul_q[61:30];
	assign lval   = {p_q, frac_q};
	assign yv     = (mul_q + 64'h8000_0000) >> 32;
	assign e      = 22'(idx_q) * K_DQ_STEP + K_DQ_OFS;
	assign n      = e[21:16];
	assign fbit   = e[4'd15 - cmd.k[3:0]];

	always_comb begin
		if (n >= 6'd30)
			v64 = 64'(acc_q) << (n - 6'd30);
		else
			v64 = (64'(acc_q) + (64'd1 << (6'd29 - n))) >> (6'd30 - n);
		vsat = (v64 > 64'(VAL_MAX)) ? VAL_MAX : v64[33:0];
	end

	// one shared multiplier, operands picked by the command
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_SQT: begin
				mul_a = 32'(tmag_q);
				mul_b = 32'(tmag_q);
			end
			OP_SQS: begin
				mul_a = 32'(smag_q);
				mul_b = 32'(smag_q);
			end
			OP_PSTEP: begin
				unique case (cmd.k)
					6'd0: begin mul_a = ses_q[31:0];  mul_b = tps_q[31:0];  end
					6'd1: begin mul_a = ses_q[31:0];  mul_b = tps_q[63:32]; end
					6'd2: begin mul_a = ses_q[63:32]; mul_b = tps_q[31:0];  end
					6'd3: begin mul_a = ses_q[63:32]; mul_b = tps_q[63:32]; end
					6'd4: begin mul_a = sps_q[31:0];  mul_b = wid;          end
					6'd5: begin mul_a = sps_q[63:32]; mul_b = wid;          end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			OP_LMUL: begin
				mul_a = 32'(m_q);
				mul_b = 32'(m_q);
			end
			OP_IMUL: begin
				mul_a = 32'(lval - K_LOG_OFS);
				mul_b = K_IDX_GAIN;
			end
			OP_EMUL: begin
				mul_a = 32'(acc_q);
				mul_b = exp2_root(cmd.k[3:0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign stat.band_end   = bend_q;
	assign stat.power_mode = pmode_q;
	assign stat.sat        = (prod_q[127:64] >= d_q);
	assign stat.env_zero   = (env_q == '0);
	assign stat.env_top    = env_q[63];
	assign stat.out_free   = !out_valid_q || !out_stall;

	// control state and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmode_q     <= 1'b0;
			tes_q       <= 64'd1;
			tps_q       <= 64'd1;
			ses_q       <= 64'd1;
			sps_q       <= 64'd1;
			line_q      <= '0;
			band_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				pmode_q <= cfg_wr_data;
			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_SQS: begin
					if (acc_en)
						tes_q <= tes_q + mul_q;
				end
				OP_ACC: begin
					if (acc_en) begin
						ses_q  <= ses_q + mul_q;
						tps_q  <= tps_q + 64'(tpow_q);
						sps_q  <= sps_q + 64'(spow_q);
						line_q <= line_q + 1'b1;
					end
				end
				OP_OUT: begin
					tes_q       <= 64'd1;
					tps_q       <= 64'd1;
					ses_q       <= 64'd1;
					sps_q       <= 64'd1;
					line_q      <= '0;
					if (fend_q || (32'(band_q) + 1 >= MAX_BANDS))
						band_q <= '0;
					else
						band_q <= band_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		unique case (cmd.op)
			OP_LOAD: begin
				tmag_q <= mag24(target_mdct);
				smag_q <= mag24(source_mdct);
				tpow_q <= target_power;
				spow_q <= source_power;
				bend_q <= band_last | frame_last;
				fend_q <= frame_last;
			end
			OP_PSTEP: begin
				unique case (cmd.k)
					6'd1: prod_q <= {64'd0, mul_q};
					6'd2: prod_q <= prod_q + {32'd0, mul_q, 32'd0};
					6'd3: prod_q <= prod_q + {32'd0, mul_q, 32'd0};
					6'd4: prod_q <= prod_q + {mul_q, 64'd0};
					6'd5: d_q    <= mul_q;
					6'd6: d_q    <= d_q + {mul_q[31:0], 32'd0};
					default: ;
				endcase
			end
			OP_MSET: begin
				prod_q <= {64'd0, tes_q};
				d_q    <= 64'(wid);
			end
			OP_DINIT: begin
				rem_q <= prod_q[127:64];
				env_q <= '0;
			end
			OP_DSAT: env_q <= '1;
			OP_DSTEP: begin
				prod_q[63:0] <= {prod_q[62:0], 1'b0};
				if (r2 >= d_q) begin
					rem_q <= r2 - d_q;
					env_q <= {env_q[62:0], 1'b1};
				end else begin
					rem_q <= r2;
					env_q <= {env_q[62:0], 1'b0};
				end
			end
			OP_NINIT: p_q <= 6'd63;
			OP_NSTEP: begin
				env_q <= {env_q[62:0], 1'b0};
				p_q   <= p_q - 6'd1;
			end
			OP_LINIT: begin
				m_q    <= env_q[63:33];
				frac_q <= '0;
			end
			OP_LUPD: begin
				// squared mantissa at or above two gives a one bit
				if (sq[31]) begin
					m_q    <= sq[31:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= sq[30:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			OP_IMUL: lneg_q <= (lval < K_LOG_OFS);
			OP_IUPD: begin
				acc_q <= ONE_Q30;
				if (lneg_q)
					idx_q <= '0;
				else if (yv > 64'(IDX_MAX))
					idx_q <= IDX_MAX;
				else
					idx_q <= yv[6:0];
			end
			OP_IZERO: begin
				acc_q <= ONE_Q30;
				idx_q <= '0;
			end
			OP_EUPD: begin
				if (fbit)
					acc_q <= mul_q[60:30];
			end
			OP_OUT: begin
				band_out_q <= 5'(band_q);
				idx_out_q  <= idx_q;
				val_out_q  <= vsat;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign band_number    = band_out_q;
	assign envelope_index = idx_out_q;
	assign envelope_value = val_out_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DSTEP |=> rem_q < d_q)
		else $error("divider remainder not below divisor");

	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LINIT || cmd.op == OP_LUPD) |=> m_q[30])
		else $error("log2 mantissa lost normalization");

	a_val_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |=> (out_valid_q && val_out_q >= 34'd16))
		else $error("envelope value below table floor");

	a_line_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ACC && !acc_en) |=> $stable(line_q))
		else $error("line count moved past band width cap");

endmodule
